// File: hw/rtl/dual_lockout_interlock_controller_assert.svh
// Assertion macros shared by the interlock checker.
// Standalone header; no dependencies.
`ifndef DUAL_LOCKOUT_INTERLOCK_CONTROLLER_ASSERT_SVH
`define DUAL_LOCKOUT_INTERLOCK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLIC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dlic: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dlic: next-cycle check failed");

`endif

// File: hw/rtl/dlic_pkg.sv
// Types, constants and codes for the dual lockout interlock controller.
// No dependencies; imported by every other file of the block except the assertion header.
package dlic_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIMER_BITS  = 16;

  localparam int DELAY_W  = 16;
  localparam int SETTLE_W = 16;
  localparam int THRESH_W = 12;
  localparam int WIN_W    = 8;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DELAY_W-1:0]  DELAY_RST  = DELAY_W'(10000);
  localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(2000);
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(1500);
  localparam logic [WIN_W-1:0]    WIN_RST    = WIN_W'(25);

  typedef enum logic [1:0] {
    ST_STANDBY = 2'd0,
    ST_DELAY   = 2'd1,
    ST_MONITOR = 2'd2,
    ST_TRIPPED = 2'd3
  } chan_st_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY     = 2'd0,
    REG_SETTLE    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_WINDOW    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0]  delay_ms;
    logic [SETTLE_W-1:0] settle_ms;
    logic [THRESH_W-1:0] threshold;
    logic [WIN_W-1:0]    window_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic                   device;
    logic [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic      main_relay_0;
    logic      main_relay_1;
    logic      shunt_relay;
    logic      timer_relay;
    logic      pilot_light;
    logic [1:0] alert_mask;
    chan_st_t  state_0;
    chan_st_t  state_1;
  } res_t;

endpackage

// File: hw/rtl/dlic_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on dlic_pkg.
interface dlic_in_if import dlic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic                   device;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, cmd, device, sample, input ready);
  modport sink   (input valid, cmd, device, sample, output ready);
endinterface

interface dlic_out_if import dlic_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       main_relay_0;
  logic       main_relay_1;
  logic       shunt_relay;
  logic       timer_relay;
  logic       pilot_light;
  logic [1:0] alert_mask;
  logic [1:0] state_0;
  logic [1:0] state_1;

  modport source (output valid, main_relay_0, main_relay_1, shunt_relay, timer_relay,
                  pilot_light, alert_mask, state_0, state_1, input ready);
  modport sink   (input valid, main_relay_0, main_relay_1, shunt_relay, timer_relay,
                  pilot_light, alert_mask, state_0, state_1, output ready);
endinterface

// File: hw/rtl/dlic_cfg_regs.sv
// Configuration register file: delay, settle, threshold, window.
// Depends on dlic_pkg.
module dlic_cfg_regs import dlic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DELAY:     cfg_nxt.delay_ms  = cfg_wdata[DELAY_W-1:0];
        REG_SETTLE:    cfg_nxt.settle_ms = cfg_wdata[SETTLE_W-1:0];
        REG_THRESHOLD: cfg_nxt.threshold = cfg_wdata[THRESH_W-1:0];
        REG_WINDOW:    cfg_nxt.window_ms = cfg_wdata[WIN_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ms  <= DELAY_RST;
      cfg_r.settle_ms <= SETTLE_RST;
      cfg_r.threshold <= THRESH_RST;
      cfg_r.window_ms <= WIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/dlic_core.sv
// Interlock state and single-pass step logic: channel states, timers,
// relay levels and the windowed min/max span. Depends on dlic_pkg.
module dlic_core import dlic_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CMP_W  = (TIMER_BITS > DELAY_W) ?
                          ((TIMER_BITS > SETTLE_W) ? TIMER_BITS : SETTLE_W) :
                          ((DELAY_W > SETTLE_W) ? DELAY_W : SETTLE_W);
  localparam int SPAN_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [WIN_W-1:0]      WIN_MAX   = '1;

  chan_st_t              st_r   [2];
  chan_st_t              st_nxt [2];
  logic [TIMER_BITS-1:0] el_r   [2];
  logic [TIMER_BITS-1:0] el_nxt [2];
  logic [TIMER_BITS-1:0] el_inc [2];
  logic [1:0]            main_r, main_nxt;
  logic                  shunt_r, shunt_nxt;
  logic                  timer_r, timer_nxt;
  logic                  pilot_r, pilot_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [WIN_W-1:0]      wc_r, wc_nxt;

  logic [WIN_W-1:0]       wc_inc;
  logic [WIN_W-1:0]       win_len;
  logic                   win_end;
  logic [1:0]             expire;
  logic [SAMPLE_BITS-1:0] span;
  logic                   trip;
  logic [1:0]             alert_c;

  // tick arithmetic, computed from the current state
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if ((st_r[i] == ST_DELAY || st_r[i] == ST_MONITOR) && el_r[i] != TIMER_MAX) begin
        el_inc[i] = el_r[i] + TIMER_BITS'(1);
      end else begin
        el_inc[i] = el_r[i];
      end
      expire[i] = CMP_W'(el_inc[i]) >= CMP_W'(cfg.delay_ms);
    end
  end

  assign wc_inc  = (wc_r != WIN_MAX) ? wc_r + WIN_W'(1) : wc_r;
  assign win_len = (cfg.window_ms == '0) ? WIN_W'(1) : cfg.window_ms;
  assign win_end = wc_inc >= win_len;
  // empty window leaves min above max: span reads zero
  assign span    = (max_r >= min_r) ? max_r - min_r : '0;
  assign trip    = (st_r[0] == ST_MONITOR) && win_end &&
                   (CMP_W'(el_inc[0]) > CMP_W'(cfg.settle_ms)) &&
                   (SPAN_W'(span) > SPAN_W'(cfg.threshold));

  // next state
  always_comb begin
    st_nxt    = st_r;
    el_nxt    = el_r;
    main_nxt  = main_r;
    shunt_nxt = shunt_r;
    timer_nxt = timer_r;
    pilot_nxt = pilot_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    wc_nxt    = wc_r;
    case (item.cmd)
      CMD_TICK: begin
        for (int i = 0; i < 2; i++) begin
          if (st_r[i] == ST_DELAY && expire[i]) begin
            main_nxt[i] = 1'b0;
            pilot_nxt   = 1'b0;
            st_nxt[i]   = ST_MONITOR;
            el_nxt[i]   = '0;
          end else begin
            el_nxt[i] = el_inc[i];
          end
        end
        // channel 0 in monitoring excludes any delay expiry on a tripping channel
        if (trip) begin
          shunt_nxt = 1'b0;
          timer_nxt = 1'b0;
          for (int j = 0; j < 2; j++) begin
            if (st_r[j] == ST_MONITOR) begin
              st_nxt[j] = ST_TRIPPED;
            end
          end
        end
        if (win_end) begin
          max_nxt = '0;
          min_nxt = '1;
          wc_nxt  = '0;
        end else begin
          wc_nxt = wc_inc;
        end
      end
      CMD_START: begin
        if (st_r[item.device] != ST_STANDBY) begin
          main_nxt[item.device] = 1'b1;
        end
        st_nxt[item.device] = ST_DELAY;
        el_nxt[item.device] = '0;
      end
      CMD_STOP: begin
        st_nxt[item.device]   = ST_STANDBY;
        el_nxt[item.device]   = '0;
        main_nxt[item.device] = 1'b1;
        if (st_nxt[0] == ST_STANDBY && st_nxt[1] == ST_STANDBY) begin
          shunt_nxt = 1'b1;
          timer_nxt = 1'b1;
          pilot_nxt = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (item.sample > max_r) begin
          max_nxt = item.sample;
        end
        if (item.sample < min_r) begin
          min_nxt = item.sample;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  // result word
  always_comb begin
    alert_c = '0;
    if (item.cmd == CMD_TICK && trip) begin
      alert_c[0] = 1'b1;
      alert_c[1] = (st_r[1] == ST_MONITOR);
    end
    res.main_relay_0 = main_nxt[0];
    res.main_relay_1 = main_nxt[1];
    res.shunt_relay  = shunt_nxt;
    res.timer_relay  = timer_nxt;
    res.pilot_light  = pilot_nxt;
    res.alert_mask   = alert_c;
    res.state_0      = st_nxt[0];
    res.state_1      = st_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0]  <= ST_STANDBY;
      st_r[1]  <= ST_STANDBY;
      el_r[0]  <= '0;
      el_r[1]  <= '0;
      main_r   <= '1;
      shunt_r  <= 1'b1;
      timer_r  <= 1'b1;
      pilot_r  <= 1'b1;
      max_r    <= '0;
      min_r    <= '1;
      wc_r     <= '0;
    end else if (en) begin
      st_r     <= st_nxt;
      el_r     <= el_nxt;
      main_r   <= main_nxt;
      shunt_r  <= shunt_nxt;
      timer_r  <= timer_nxt;
      pilot_r  <= pilot_nxt;
      max_r    <= max_nxt;
      min_r    <= min_nxt;
      wc_r     <= wc_nxt;
    end
  end

endmodule

// File: hw/rtl/dual_lockout_interlock_controller.sv
// Dual lockout interlock controller, top level.
// Accepted words wait in the command register; results wait in the result register.
// Throughput: one word per cycle; the step logic between the command register
// and the result register is single pass, so back-to-back words are taken every
// cycle while the result side keeps up; a stalled result fills both registers.
// Reset (rst_n low, synchronous): channels standby, timers and window cleared,
// all relay levels high, configuration back to its default values.
module dual_lockout_interlock_controller import dlic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dlic_in_if.sink               in_port,
  dlic_out_if.source            out_port,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r, item_nxt;
  logic  stage_v_r, stage_v_nxt;
  res_t  res_c;
  res_t  out_r, out_nxt;
  logic  out_v_r, out_v_nxt;

  logic  in_acc;
  logic  advance;
  logic  fire;

  dlic_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is empty or being drained.
  // fire: the staged command word is executed and its result captured.
  assign advance       = !out_v_r || out_port.ready;
  assign fire          = stage_v_r && advance;
  assign in_port.ready = !stage_v_r || advance;
  assign in_acc        = in_port.valid && in_port.ready;

  // command register
  always_comb begin
    item_nxt    = item_r;
    stage_v_nxt = stage_v_r;
    if (in_acc) begin
      item_nxt.cmd    = cmd_t'(in_port.cmd);
      item_nxt.device = in_port.device;
      item_nxt.sample = in_port.sample;
      stage_v_nxt     = 1'b1;
    end else if (fire) begin
      stage_v_nxt = 1'b0;
    end
  end

  // State advances only on fire, so each word sees the state its
  // predecessor left behind.
  dlic_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res_c)
  );

  // result register
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (fire) begin
      out_nxt   = res_c;
      out_v_nxt = 1'b1;
    end else if (out_port.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_port.valid        = out_v_r;
  assign out_port.main_relay_0 = out_r.main_relay_0;
  assign out_port.main_relay_1 = out_r.main_relay_1;
  assign out_port.shunt_relay  = out_r.shunt_relay;
  assign out_port.timer_relay  = out_r.timer_relay;
  assign out_port.pilot_light  = out_r.pilot_light;
  assign out_port.alert_mask   = out_r.alert_mask;
  assign out_port.state_0      = out_r.state_0;
  assign out_port.state_1      = out_r.state_1;

endmodule

// File: hw/rtl/dlic_checker.sv
// Port-level checks on the interlock result channel, bound to the top level.
// Depends on dlic_pkg and dual_lockout_interlock_controller_assert.svh.
`include "dual_lockout_interlock_controller_assert.svh"

module dlic_checker import dlic_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       shunt_relay,
  input logic       timer_relay,
  input logic       pilot_light,
  input logic [1:0] alert_mask,
  input logic [1:0] state_0,
  input logic [1:0] state_1
);

  logic [8:0] word_c;

  assign word_c = {shunt_relay, timer_relay, pilot_light, alert_mask, state_0, state_1};

  // an alerted channel has actually tripped, and the trip dropped shunt and timer
  `DLIC_ASSERT_IMPLY(a_alert_trips, clk, rst_n, out_valid && alert_mask != 2'b00, !shunt_relay && !timer_relay && state_0 == ST_TRIPPED && (!alert_mask[1] || state_1 == ST_TRIPPED))

  // a tripped channel keeps the shunt relay down
  `DLIC_ASSERT_IMPLY(a_trip_shunt_low, clk, rst_n, out_valid && (state_0 == ST_TRIPPED || state_1 == ST_TRIPPED), !shunt_relay)

  // both channels at standby means the pilot light, shunt and timer relays are back on
  `DLIC_ASSERT_IMPLY(a_standby_pilot, clk, rst_n, out_valid && state_0 == ST_STANDBY && state_1 == ST_STANDBY, pilot_light && shunt_relay && timer_relay)

  // a stalled result word holds
  `DLIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word_c))

endmodule

bind dual_lockout_interlock_controller dlic_checker u_dlic_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_port.valid),
  .out_ready   (out_port.ready),
  .shunt_relay (out_port.shunt_relay),
  .timer_relay (out_port.timer_relay),
  .pilot_light (out_port.pilot_light),
  .alert_mask  (out_port.alert_mask),
  .state_0     (out_port.state_0),
  .state_1     (out_port.state_1)
);
